[sv/tssh_pkg.sv]
// ----------------------------------------------------------------------------
// tssh_pkg
// Types, constants and the scatter table of the string hash.
// ----------------------------------------------------------------------------
package tssh_pkg;

  localparam int KEY_W    = 32;
  localparam int BYTE_W   = 8;
  localparam int BKT_W    = 16;
  localparam int CNT_W    = 17;
  localparam logic [CNT_W-1:0] BUCKET_RESET = 17'd256;
  localparam logic [CNT_W-1:0] BUCKET_MAX   = 17'd65536;

  // one finished string, front to back
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] div;
  } job_t;

  localparam logic [31:0] SCATTER [256] = '{
     32'd254970132, 32'd2009114045, 32'd1555322802, 32'd1898824451,
     32'd960045696, 32'd1960239289,     32'd802046, 32'd1782549599,
    32'd1246619308, 32'd1954271093, 32'd2070620938,  32'd125472635,
     32'd990429592,  32'd558296561,   32'd18410966, 32'd1503176791,
    32'd1939103556, 32'd1573615661, 32'd1309544802, 32'd1494577907,
     32'd303705008,  32'd680815145,   32'd71295406,    32'd9063247,
     32'd737039068, 32'd1138786277, 32'd1571580602,  32'd818564459,
    32'd1971044552,  32'd488519009,   32'd69630086,  32'd985552199,
    32'd2096111988,  32'd807913117,  32'd434214674,  32'd721485539,
    32'd1671946464, 32'd1648308121, 32'd1052643934,  32'd859481663,
    32'd1113205516,  32'd281685077,  32'd508884586, 32'd1295869787,
     32'd604302328, 32'd1338915025, 32'd1388580662, 32'd1944133175,
    32'd1134088100,  32'd338465037,  32'd674883778,  32'd228550355,
    32'd2019901968, 32'd1167995145,  32'd222416654, 32'd1693424943,
    32'd2101636924, 32'd1953486021, 32'd1003474458, 32'd1247993163,
    32'd2122793768,  32'd788396097, 32'd1728885222, 32'd1015022375,
     32'd446786004,  32'd854644605, 32'd2044855922,  32'd828353219,
    32'd1100304192, 32'd1983409785,  32'd843454398, 32'd1577594911,
     32'd522198892, 32'd1137211701,  32'd625471946,  32'd394899259,
    32'd2074461784, 32'd1746170801, 32'd2010865814,  32'd702153751,
    32'd1071443972,  32'd692820461, 32'd1483010082, 32'd1081133747,
     32'd121309296,  32'd123004905,   32'd84274286, 32'd1017339663,
    32'd1830828956, 32'd2139822501, 32'd1789419898,  32'd364961067,
      32'd12809608, 32'd1345891105,  32'd684399430,  32'd518922503,
     32'd199123508, 32'd2010372189,  32'd101557714, 32'd1321322147,
     32'd404319648, 32'd1811586393,  32'd561794334, 32'd1688218111,
    32'd1597490124, 32'd1143911957, 32'd1822170410,  32'd131557147,
     32'd302207160, 32'd1414635153,  32'd976675318, 32'd1014716919,
     32'd569950308, 32'd1927320269, 32'd1843865474, 32'd1241620115,
    32'd2041806544, 32'd1727041225,  32'd409221582, 32'd1872597231,
    32'd1343862780,  32'd971656837,  32'd210642138,   32'd39603467,
      32'd38295528, 32'd1762020865,  32'd960083110, 32'd1358999271,
     32'd541002388,  32'd847825213, 32'd1404859698, 32'd1772049027,
     32'd407649280, 32'd2059254841,  32'd523809406,  32'd486183903,
     32'd758716460,   32'd78963445, 32'd1554610314, 32'd1537117947,
     32'd590711576, 32'd2059254129,  32'd799970134, 32'd1220354007,
    32'd1334067396,   32'd44268461,   32'd68718306,  32'd516547187,
    32'd1994827056, 32'd1504257449, 32'd1077196590, 32'd1104556751,
     32'd650699868,  32'd876966757, 32'd1339627578,  32'd464334059,
    32'd1965943368, 32'd1570693345, 32'd1412464134,  32'd498052295,
    32'd1398498036, 32'd1388816925,   32'd71726226,   32'd74468963,
    32'd1598405216, 32'd1438239513,  32'd173230046,  32'd957312447,
    32'd1606163596,  32'd873660373, 32'd1774715882, 32'd1817650907,
    32'd1465152888, 32'd1032897617,  32'd974812342, 32'd1201100215,
    32'd1511485732,  32'd642536589, 32'd1112614466, 32'd1329698387,
     32'd300710800, 32'd1354149001, 32'd1095722126, 32'd1397048495,
     32'd499499196,  32'd995395653, 32'd1860254618,  32'd153844939,
     32'd931933352,  32'd238707649,   32'd25655142,  32'd737352359,
    32'd1288399700,   32'd71858941, 32'd1157866482, 32'd1034730051,
    32'd1981671616,  32'd740739577,  32'd228855102, 32'd1188476831,
    32'd2035863788, 32'd1023478965,  32'd340770634,  32'd796470971,
    32'd1115164632, 32'd2063777585,  32'd122848790,  32'd235010967,
    32'd2135576964, 32'd1737694573, 32'd1541991842,  32'd132168243,
    32'd1239220720,  32'd961618793,  32'd747389422,  32'd534955663,
     32'd229133596, 32'd1473219877,  32'd805211898,  32'd240073899,
     32'd326835976, 32'd1460721313,  32'd353804486, 32'd2126706823,
    32'd1613177780,  32'd784546781, 32'd1330381650, 32'd1338807843,
    32'd1374471968,  32'd691845337,  32'd537068190,  32'd810054015,
     32'd682046796, 32'd1178012053, 32'd1754835626,  32'd914138779,
    32'd1689803320,  32'd223062545,  32'd288278390, 32'd1291129207,
     32'd682942948,  32'd204461645,  32'd272098562,  32'd287264275,
     32'd164640848, 32'd2091944521, 32'd1589858126, 32'd2141632623,
    32'd2064157052, 32'd1315865093, 32'd1703481946,  32'd177237131,
    32'd1058193768,  32'd274348417,  32'd783677990, 32'd1964459623
  };

endpackage

[sv/tssh_front.sv]
// ----------------------------------------------------------------------------
// tssh_front
// Accepts bytes, runs the shift-add key and pushes finished strings.
// ----------------------------------------------------------------------------
module tssh_front import tssh_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] in_char_byte,
  input  logic [CNT_W-1:0]  bucket_count,
  output logic              push,
  output job_t              push_job,
  input  logic              q_full
);

  logic [KEY_W-1:0] key_r, key_nxt;
  logic [CNT_W-1:0] div;
  logic             take;

  assign in_stall = q_full;
  assign take     = in_valid && !q_full;
  assign push     = take && (in_char_byte == '0);

  // clamp the divisor into 1..65536
  always_comb begin
    priority if (bucket_count == '0) begin
      div = CNT_W'(1);
    end else if (bucket_count > BUCKET_MAX) begin
      div = BUCKET_MAX;
    end else begin
      div = bucket_count;
    end
  end

  assign push_job.key = key_r;
  assign push_job.div = div;

  always_comb begin
    key_nxt = key_r;
    if (take) begin
      if (in_char_byte == '0) begin
        key_nxt = '0;
      end else begin
        key_nxt = {key_r[KEY_W-2:0], 1'b0} + SCATTER[in_char_byte];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else begin
      key_r <= key_nxt;
    end
  end

endmodule

[sv/tssh_queue.sv]
// ----------------------------------------------------------------------------
// tssh_queue
// Two-entry queue between the byte front end and the modulo back end.
// ----------------------------------------------------------------------------
module tssh_queue import tssh_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic avail,
  output job_t head
);

  job_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign avail = (cnt_r != 2'd0);
  assign head  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !avail |-> !pop) else $error("pop from empty queue");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd2) else $error("queue count out of range");
`endif

endmodule

[sv/tssh_back.sv]
// ----------------------------------------------------------------------------
// tssh_back
// Restoring divider: one remainder bit per cycle, then the result register.
// ----------------------------------------------------------------------------
module tssh_back import tssh_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             avail,
  input  job_t             head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [BKT_W-1:0] out_bucket,
  output logic [KEY_W-1:0] out_raw_key
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0]       st_r, st_nxt;
  logic [KEY_W-1:0] key_r, sh_r;
  logic [CNT_W-1:0] div_r, rem_r;
  logic [4:0]       bit_r;
  logic [CNT_W:0]   trial;
  logic [CNT_W:0]   diff;

  assign pop   = (st_r == S_IDLE) && avail;
  assign trial = {rem_r, sh_r[KEY_W-1]};
  assign diff  = trial - {1'b0, div_r};

  assign out_valid   = (st_r == S_OUT);
  assign out_bucket  = rem_r[BKT_W-1:0];
  assign out_raw_key = key_r;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE:  if (avail) st_nxt = S_DIV;
      S_DIV:   if (bit_r == 5'd31) st_nxt = S_OUT;
      S_OUT:   if (!out_stall) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      key_r <= head.key;
      sh_r  <= head.key;
      div_r <= head.div;
      rem_r <= '0;
      bit_r <= '0;
    end else if (st_r == S_DIV) begin
      sh_r  <= {sh_r[KEY_W-2:0], 1'b0};
      bit_r <= bit_r + 5'd1;
      // subtract the divisor only when the trial remainder reaches it
      if (!diff[CNT_W]) begin
        rem_r <= diff[CNT_W-1:0];
      end else begin
        rem_r <= trial[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

`ifndef SYNTHESIS
  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, rem_r} < {1'b0, div_r})) else $error("remainder not reduced");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_raw_key))
    else $error("result dropped under stall");
  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(st_r, 32) == S_DIV) else $error("divide length wrong");
`endif

endmodule

[sv/table_scatter_string_hash.sv]
// ----------------------------------------------------------------------------
// table_scatter_string_hash
// String hash with table-driven shift-add key and bucket modulo.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle while the queue has room; each nonzero byte
// updates the key as key*2 + SCATTER[byte]. A zero byte ends the string and
// queues the key for a restoring divider that produces one remainder bit per
// cycle, then holds its result until the receiver takes it. A two-entry queue
// lets bytes of the following strings keep flowing while a divide runs; the
// input stalls only when the queue fills.
module table_scatter_string_hash import tssh_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [BYTE_W-1:0]    in_char_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [BKT_W-1:0]     out_bucket,
  output logic [KEY_W-1:0]     out_raw_key,
  input  logic                 cfg_we,
  input  logic [CNT_W-1:0]     cfg_wdata
);

  logic [CNT_W-1:0] bcount_r;
  logic             push, q_full, pop, avail;
  job_t             push_job, head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bcount_r <= BUCKET_RESET;
    end else if (cfg_we) begin
      bcount_r <= cfg_wdata;
    end
  end

  tssh_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_char_byte,
    .bucket_count(bcount_r), .push, .push_job, .q_full
  );

  tssh_queue u_queue (
    .clk, .rst_n, .push, .push_job, .full(q_full), .pop, .avail, .head
  );

  tssh_back u_back (
    .clk, .rst_n, .avail, .head, .pop, .out_valid, .out_stall,
    .out_bucket, .out_raw_key
  );

endmodule

[sim/table_scatter_string_hash_tb.sv]
// ----------------------------------------------------------------------------
// table_scatter_string_hash_tb
// Self-checking testbench for the table-driven string hash.
// ----------------------------------------------------------------------------
// Strings are sent one byte per item. A local key model predicts key and
// bucket for each zero byte; a monitor compares results in order. Bucket
// counts cover the reset value, one, the maximum, zero and values above it.
// ----------------------------------------------------------------------------
module table_scatter_string_hash_tb;
  import tssh_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 100;

  typedef struct {
    logic [BKT_W-1:0] bucket;
    logic [KEY_W-1:0] key;
  } hash_res_t;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [BYTE_W-1:0] in_char_byte;
  logic             out_valid;
  logic             out_stall;
  logic [BKT_W-1:0] out_bucket;
  logic [KEY_W-1:0] out_raw_key;
  logic             cfg_we;
  logic [CNT_W-1:0] cfg_wdata;

  logic [KEY_W-1:0] model_key;
  logic [CNT_W-1:0] model_count;
  hash_res_t        pending_hashes[$];
  int               errors;
  int               idle_cycles;
  int               send_idle_pct;
  int               recv_stall_pct;
  int               bytes_sent;
  int               hashes_seen;

  table_scatter_string_hash dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_char_byte(in_char_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_bucket(out_bucket), .out_raw_key(out_raw_key),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // advance the key model by one accepted byte
  task automatic hash_byte(input logic [BYTE_W-1:0] b);
    logic [CNT_W-1:0] div;
    hash_res_t r;
    if (b != '0) begin
      model_key = (model_key << 1) + SCATTER[b];
    end else begin
      if (model_count == '0) div = CNT_W'(1);
      else if (model_count > BUCKET_MAX) div = BUCKET_MAX;
      else div = model_count;
      r.key = model_key;
      r.bucket = BKT_W'(model_key % div);
      pending_hashes.push_back(r);
      model_key = '0;
    end
  endtask

  // valid stays high after an accepted item until the next idle cycle
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    hash_byte(b);
    bytes_sent++;
  endtask

  task automatic send_string(input int len);
    repeat (len) send_byte(BYTE_W'($urandom_range(255, 1)));
    send_byte('0);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_hashes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(input logic [CNT_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    model_count = v;
  endtask

  task automatic set_idling(input int s, input int r);
    send_idle_pct = s;
    recv_stall_pct = r;
  endtask

  task automatic test_directed();
    send_byte('0);                       // empty string
    send_byte(8'hff); send_byte('0);
    send_byte(8'h01); send_byte('0);
    send_string(1);
    repeat (3) send_byte(8'haa);
    repeat (3) send_byte(8'h55);
    send_byte('0);
    // long string lets the shift wrap the key
    repeat (12) send_byte(8'hff);
    send_byte('0);
  endtask

  task automatic test_counts();
    logic [CNT_W-1:0] counts[6];
    counts = '{17'd1, 17'd65536, 17'd0, 17'h1ffff, 17'd65537, 17'd1000};
    foreach (counts[i]) begin
      wait_drain();
      write_count(counts[i]);
      send_string(5);
      send_byte('0);
    end
  endtask

  // change the count mid-string: the running key carries over
  task automatic test_midstring_write();
    send_byte(8'h3c); send_byte(8'hc3);
    wait_drain();
    write_count(17'd7);
    send_byte(8'h81);
    send_byte('0);
  endtask

  task automatic test_random(input int n_bytes);
    int target;
    target = bytes_sent + n_bytes;
    while (bytes_sent < target) begin
      if ($urandom_range(9) == 0) begin
        wait_drain();
        write_count($urandom_range(3) == 0 ? CNT_W'($urandom)
                                           : CNT_W'($urandom_range(65536, 1)));
      end
      if ($urandom_range(3) == 0) send_string($urandom_range(40));
      else send_string($urandom_range(8));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_char_byte = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    model_key = '0;
    model_count = BUCKET_RESET;
    errors = 0;
    bytes_sent = 0;
    hashes_seen = 0;
    set_idling(0, 0);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_counts();
    test_midstring_write();
    set_idling(0, 0);  test_random(450);
    set_idling(54, 0); test_random(450);
    wait_drain();      // sender holds until all results are back
    set_idling(0, 54); test_random(450);
    set_idling(23, 23); test_random(450);
    wait_drain();
    $display("covered %0d bytes, %0d hashes, bucket counts 0..2^17-1 and idling mixes",
             bytes_sent, hashes_seen);
    if (errors == 0) $display("table_scatter_string_hash regression: pass");
    else $display("table_scatter_string_hash regression: fail");
    $finish;
  end

  // receiver stall and result checking
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        hashes_seen++;
        if (pending_hashes.size() == 0) begin
          $display("%0t unexpected result bucket %0d key %h", $time, out_bucket,
                   out_raw_key);
          errors++;
        end else begin
          if (out_bucket !== pending_hashes[0].bucket ||
              out_raw_key !== pending_hashes[0].key) begin
            $display("%0t mismatch: expected bucket %0d key %h, actual bucket %0d key %h",
                     $time, pending_hashes[0].bucket, pending_hashes[0].key,
                     out_bucket, out_raw_key);
            errors++;
          end
          void'(pending_hashes.pop_front());
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // watchdog on cycles with no accepted item on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout waiting for handshake");
      $display("table_scatter_string_hash regression: fail");
      $finish;
    end
  end

endmodule
